### sv/i2cw_pkg.sv
// Shared types and constants for the I2C master write sequencer.
package i2cw_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_START_WAIT  = 4'd1,
    PH_START_SCL   = 4'd2,
    PH_BIT_SETUP   = 4'd3,
    PH_BIT_RELEASE = 4'd4,
    PH_BIT_WAIT    = 4'd5,
    PH_BIT_EXTRA   = 4'd6,
    PH_STOP_REL    = 4'd7,
    PH_STOP_WAIT   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // Pin levels and busy flag carried from the sequencer to the result stage.
  typedef struct packed {
    logic scl_pull_low;
    logic sda_pull_low;
    logic busy_res;
  } res_t;

  localparam logic [7:0] SHIFT_IDLE   = 8'hFF;
  localparam logic [7:0] WAIT_MAX     = 8'hFF;
  localparam logic [3:0] ACK_BIT      = 4'd8;
  localparam logic [3:0] BITS_PER_BYTE = 4'd9;

endpackage

### sv/i2cw_core.sv
// Bus sequencer: phase state machine, shift register and counters, one step per item.
module i2cw_core import i2cw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  input  logic       scl_in,
  input  logic [7:0] extra_wait_ticks,
  output res_t       res_nxt
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] wait_cnt_r, wait_cnt_nxt;
  logic       scl_low_r, scl_low_nxt;
  logic       sda_low_r, sda_low_nxt;

  logic [3:0] bit_inc;
  logic [7:0] wait_inc;
  logic       last_bit;
  logic       extra_done;
  logic       end_clock;
  cmd_t       cmd_c;

  assign cmd_c      = cmd_t'(cmd);
  assign bit_inc    = bit_cnt_r + 4'd1;
  assign last_bit   = (bit_inc >= BITS_PER_BYTE);
  assign wait_inc   = (wait_cnt_r < WAIT_MAX) ? wait_cnt_r + 8'd1 : wait_cnt_r;
  assign extra_done = (wait_inc >= extra_wait_ticks);

  // SCL goes low at the end of a bit clock in either the wait or the extra-wait phase
  always_comb begin
    end_clock = 1'b0;
    case (phase_r)
      PH_BIT_WAIT:  end_clock = scl_in && (extra_wait_ticks == 8'd0);
      PH_BIT_EXTRA: end_clock = extra_done;
      default:      end_clock = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_START_WAIT:  if (scl_in) phase_nxt = PH_START_SCL;
      PH_START_SCL:   phase_nxt = PH_BIT_SETUP;
      PH_BIT_SETUP:   phase_nxt = PH_BIT_RELEASE;
      PH_BIT_RELEASE: phase_nxt = PH_BIT_WAIT;
      PH_BIT_WAIT: begin
        if (end_clock)   phase_nxt = last_bit ? PH_IDLE : PH_BIT_SETUP;
        else if (scl_in) phase_nxt = PH_BIT_EXTRA;
      end
      PH_BIT_EXTRA: begin
        if (end_clock) phase_nxt = last_bit ? PH_IDLE : PH_BIT_SETUP;
      end
      PH_STOP_REL:  phase_nxt = PH_STOP_WAIT;
      PH_STOP_WAIT: if (scl_in) phase_nxt = PH_IDLE;
      default: begin
        case (cmd_c)
          CMD_START: phase_nxt = PH_START_WAIT;
          CMD_WRITE: phase_nxt = PH_BIT_SETUP;
          CMD_STOP:  phase_nxt = PH_STOP_REL;
          default:   phase_nxt = PH_IDLE;
        endcase
      end
    endcase
  end

  // datapath and pin levels
  always_comb begin
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    scl_low_nxt  = scl_low_r;
    sda_low_nxt  = sda_low_r;
    case (phase_r)
      PH_START_WAIT: if (scl_in) sda_low_nxt = 1'b1;
      PH_START_SCL: begin
        scl_low_nxt = 1'b1;
        sda_low_nxt = 1'b0;
        bit_cnt_nxt = 4'd0;
      end
      PH_BIT_SETUP: begin
        scl_low_nxt = 1'b1;
        // the ACK bit leaves SDA released
        sda_low_nxt = (bit_cnt_r >= ACK_BIT) ? 1'b0 : ~shift_r[7];
      end
      PH_BIT_RELEASE: scl_low_nxt = 1'b0;
      PH_BIT_WAIT:    if (scl_in) wait_cnt_nxt = 8'd0;
      PH_BIT_EXTRA:   wait_cnt_nxt = wait_inc;
      PH_STOP_REL:    scl_low_nxt = 1'b0;
      PH_STOP_WAIT:   if (scl_in) sda_low_nxt = 1'b0;
      default: begin
        case (cmd_c)
          CMD_START: begin
            scl_low_nxt = 1'b0;
            shift_nxt   = data_byte;
            bit_cnt_nxt = 4'd0;
          end
          CMD_WRITE: begin
            scl_low_nxt = 1'b1;
            shift_nxt   = data_byte;
            bit_cnt_nxt = 4'd0;
          end
          CMD_STOP: sda_low_nxt = 1'b1;
          default: ;
        endcase
      end
    endcase
    if (end_clock) begin
      scl_low_nxt  = 1'b1;
      wait_cnt_nxt = 8'd0;
      if (last_bit) begin
        sda_low_nxt = 1'b0;
        shift_nxt   = SHIFT_IDLE;
        bit_cnt_nxt = 4'd0;
      end else begin
        shift_nxt   = {shift_r[6:0], 1'b1};
        bit_cnt_nxt = bit_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      shift_r    <= SHIFT_IDLE;
      bit_cnt_r  <= 4'd0;
      wait_cnt_r <= 8'd0;
      scl_low_r  <= 1'b0;
      sda_low_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      scl_low_r  <= scl_low_nxt;
      sda_low_r  <= sda_low_nxt;
    end
  end

  assign res_nxt.scl_pull_low = scl_low_nxt;
  assign res_nxt.sda_pull_low = sda_low_nxt;
  assign res_nxt.busy_res     = (phase_nxt != PH_IDLE);

endmodule

### sv/i2cw_out.sv
// Result register with valid/stall handshake; frees the input side when empty or draining.
module i2cw_out import i2cw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_nxt,
  output logic room,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign room      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

### sv/i2c_master_write_sequencer.sv
// Top level of the I2C master write sequencer.
//
// Each input item is one bus tick: an optional command (start plus address,
// write byte, stop) and the sensed SCL level. Each accepted item yields exactly
// one result item: the SCL and SDA pull-low levels after that tick, and a busy
// flag. Commands are honoured only while the sequencer is idle.
// Channels use valid/stall; an item moves when valid is high and stall low.
// The result register drives out_* in the cycle after the input is accepted.
// Throughput: one item per cycle while in_stall is low; the sequencer state
// and the result register are both updated in the accepting cycle, so items
// may arrive back to back. When the receiver stalls, the result register holds
// its item and in_stall is raised only while that full register is stalled; it
// clears the cycle the item is taken.
// Reset (rst_n low, synchronous): sequencer idle, both lines released,
// shift register all ones, counters zero, extra_wait_ticks zero, no result.
// cfg_wr_en writes extra_wait_ticks, the number of ticks SCL stays released
// after it reads high; write it only while idle.
module i2c_master_write_sequencer import i2cw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_scl_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_pull_low,
  output logic       out_sda_pull_low,
  output logic       out_busy_res
);

  logic [7:0] extra_wait_r;
  logic       room;
  logic       accept;
  res_t       res_nxt;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_wait_r <= 8'd0;
    end else if (cfg_wr_en) begin
      extra_wait_r <= cfg_wr_data;
    end
  end

  assign accept   = in_valid && room;
  assign in_stall = !room;

  i2cw_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (accept),
    .cmd              (in_cmd),
    .data_byte        (in_data_byte),
    .scl_in           (in_scl_in),
    .extra_wait_ticks (extra_wait_r),
    .res_nxt          (res_nxt)
  );

  i2cw_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_nxt   (res_nxt),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_scl_pull_low = res.scl_pull_low;
  assign out_sda_pull_low = res.sda_pull_low;
  assign out_busy_res     = res.busy_res;

endmodule

### sv/i2cw_checker.sv
// Port-level checks for the I2C master write sequencer, bound to the top level.
module i2cw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_scl_pull_low,
  input logic out_sda_pull_low,
  input logic out_busy_res
);

  // input only backs up behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // every accepted item gives a result the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_scl_pull_low)
      && $stable(out_sda_pull_low) && $stable(out_busy_res)))
    else $error("stalled result changed");

endmodule

bind i2c_master_write_sequencer i2cw_checker u_i2cw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_scl_pull_low (out_scl_pull_low),
  .out_sda_pull_low (out_sda_pull_low),
  .out_busy_res     (out_busy_res)
);

### sim/tb.sv
// Self-checking testbench for the I2C write sequencer: tick table, then random bus traffic.
module tb;
  import i2cw_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = CMD_NONE;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_scl_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_pull_low;
  logic       out_sda_pull_low;
  logic       out_busy_res;

  i2c_master_write_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .in_scl_in        (in_scl_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_pull_low (out_scl_pull_low),
    .out_sda_pull_low (out_sda_pull_low),
    .out_busy_res     (out_busy_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bus sequencer mirror, reset state
  phase_t     sq_phase = PH_IDLE;
  logic [7:0] sq_shift = SHIFT_IDLE;
  logic [3:0] sq_bits = 4'd0;
  logic [7:0] sq_wait = 8'd0;
  logic       sq_scl_low = 1'b0;
  logic       sq_sda_low = 1'b0;
  logic [7:0] wait_ticks_reg = 8'd0;

  res_t pin_levels_q[$];

  int burst_left = 0;
  int ticks_sent = 0;
  int work_ticks = 0;
  int results_seen = 0;
  int n_mismatch = 0;
  int quiet_cycles = 0;
  int in_stall_cycles = 0;

  // Script state for well-formed transactions
  bit txn_open = 1'b0;
  int bytes_left = 0;

  typedef struct {
    bit         is_cfg;
    cmd_t       cmd;
    logic [7:0] data;
    logic       scl;
    bit         typed;
    res_t       res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t tick_row(cmd_t c, logic [7:0] d, logic s, bit t, res_t r);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cmd = c;
    row.data = d;
    row.scl = s;
    row.typed = t;
    row.res = r;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [7:0] v);
    dir_row_t row;
    row = tick_row(CMD_NONE, v, 1'b0, 1'b0, 3'b000);
    row.is_cfg = 1'b1;
    return row;
  endfunction

  // SCL driven low at the end of a bit clock: next bit, or back to idle after the ninth
  task automatic close_bit_clock();
    sq_scl_low = 1'b1;
    sq_shift = {sq_shift[6:0], 1'b1};
    sq_bits = sq_bits + 4'd1;
    sq_wait = 8'd0;
    if (sq_bits >= BITS_PER_BYTE) begin
      sq_sda_low = 1'b0;
      sq_shift = SHIFT_IDLE;
      sq_bits = 4'd0;
      sq_phase = PH_IDLE;
    end else begin
      sq_phase = PH_BIT_SETUP;
    end
  endtask

  task automatic advance_bus_tick(input cmd_t c, input logic [7:0] d, input logic scl_hi,
                                  output res_t r);
    case (sq_phase)
      PH_START_WAIT: begin
        if (scl_hi) begin
          sq_sda_low = 1'b1;
          sq_phase = PH_START_SCL;
        end
      end
      PH_START_SCL: begin
        sq_scl_low = 1'b1;
        sq_sda_low = 1'b0;
        sq_bits = 4'd0;
        sq_phase = PH_BIT_SETUP;
      end
      PH_BIT_SETUP: begin
        sq_scl_low = 1'b1;
        // the ACK bit leaves SDA released
        sq_sda_low = (sq_bits >= ACK_BIT) ? 1'b0 : ~sq_shift[7];
        sq_phase = PH_BIT_RELEASE;
      end
      PH_BIT_RELEASE: begin
        sq_scl_low = 1'b0;
        sq_phase = PH_BIT_WAIT;
      end
      PH_BIT_WAIT: begin
        if (scl_hi) begin
          sq_wait = 8'd0;
          if (wait_ticks_reg == 8'd0) close_bit_clock();
          else sq_phase = PH_BIT_EXTRA;
        end
      end
      PH_BIT_EXTRA: begin
        if (sq_wait < WAIT_MAX) sq_wait = sq_wait + 8'd1;
        if (sq_wait >= wait_ticks_reg) close_bit_clock();
      end
      PH_STOP_REL: begin
        sq_scl_low = 1'b0;
        sq_phase = PH_STOP_WAIT;
      end
      PH_STOP_WAIT: begin
        if (scl_hi) begin
          sq_sda_low = 1'b0;
          sq_phase = PH_IDLE;
        end
      end
      default: begin
        sq_phase = PH_IDLE;
        case (c)
          CMD_START: begin
            sq_scl_low = 1'b0;
            sq_shift = d;
            sq_bits = 4'd0;
            sq_phase = PH_START_WAIT;
          end
          CMD_WRITE: begin
            sq_scl_low = 1'b1;
            sq_shift = d;
            sq_bits = 4'd0;
            sq_phase = PH_BIT_SETUP;
          end
          CMD_STOP: begin
            sq_sda_low = 1'b1;
            sq_phase = PH_STOP_REL;
          end
          default: ;
        endcase
      end
    endcase
    r.scl_pull_low = sq_scl_low;
    r.sda_pull_low = sq_sda_low;
    r.busy_res = (sq_phase != PH_IDLE);
  endtask

  // Offer one tick, hold it until taken, then predict its pin levels
  task automatic send_tick(input cmd_t c, input logic [7:0] d, input logic s,
                           input bit typed, input res_t typed_res);
    res_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_data_byte <= d;
    in_scl_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_bus_tick(c, d, s, r);
    pin_levels_q.push_back(typed ? typed_res : r);
    ticks_sent++;
    burst_left--;
  endtask

  // Drain every outstanding result, then write the extra wait register
  task automatic set_wait_ticks(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    wait_ticks_reg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] wait_val, input int budget);
    cmd_t       c;
    logic [7:0] d;
    logic       s;
    int         counted;
    int         pick;
    counted = 0;
    set_wait_ticks(wait_val);
    while (counted < budget) begin
      pick = $urandom_range(0, 99);
      if (sq_phase == PH_IDLE) begin
        if (pick < 10) begin
          c = cmd_t'($urandom_range(0, 3));  // stray command, breaks the script
        end else if (pick < 18) begin
          c = CMD_NONE;
        end else if (!txn_open) begin
          c = CMD_START;
          txn_open = 1'b1;
          bytes_left = $urandom_range(0, 3);
        end else if (bytes_left > 0) begin
          c = CMD_WRITE;
          bytes_left--;
        end else begin
          c = CMD_STOP;
          txn_open = 1'b0;
        end
      end else begin
        c = (pick < 12) ? cmd_t'($urandom_range(1, 3)) : CMD_NONE;
      end
      case ($urandom_range(0, 7))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      s = ($urandom_range(0, 99) < 70);
      if (!(sq_phase == PH_IDLE && c == CMD_NONE)) begin
        counted++;
        work_ticks++;
      end
      send_tick(c, d, s, 1'b0, 3'b000);
    end
  endtask

  initial begin
    // typed results are {scl_pull_low, sda_pull_low, busy_res}
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b1, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'hFF, 1'b1, 1'b1, 3'b000));
    // stop straight from reset still pulls SDA low
    dir_rows.push_back(tick_row(CMD_STOP,  8'h00, 1'b0, 1'b1, 3'b011));
    dir_rows.push_back(tick_row(CMD_START, 8'hA5, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b1, 3'b000));
    dir_rows.push_back(tick_row(CMD_START, 8'hFF, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_WRITE, 8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(cfg_row(8'd255));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_STOP,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b0, 1'b0, 3'b000));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    // wait register lowered in the middle of the extra wait
    dir_rows.push_back(cfg_row(8'd1));
    dir_rows.push_back(tick_row(CMD_NONE,  8'h00, 1'b1, 1'b0, 3'b000));
    dir_rows.push_back(cfg_row(8'd0));
    dir_rows.push_back(tick_row(CMD_WRITE, 8'h3C, 1'b0, 1'b0, 3'b000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_wait_ticks(dir_rows[i].data);
      end else begin
        send_tick(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].scl,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    random_phase(8'd2, 60);
    random_phase(8'd255, 270);
    random_phase(8'd0, 50);
    random_phase(8'd1, 30);
    random_phase(8'd7, 20);

    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d bus ticks (%0d with sequencer work), %0d results checked",
             ticks_sent, work_ticks, results_seen);
    $display("extra wait 0/1/2/7/255, one %0d-cycle receiver hold-off, input stalled %0d cycles",
             HOLD_CYCLES, in_stall_cycles);
    if (n_mismatch == 0 && pin_levels_q.size() == 0) begin
      $display("i2c_master_write_sequencer: match");
    end else begin
      $display("i2c_master_write_sequencer: mismatch");
    end
    $finish;
  end

  // Result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    bit   bad;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_pull_low, out_sda_pull_low, out_busy_res};
      results_seen <= results_seen + 1;
      bad = 1'b0;
      want = 3'b000;
      if (pin_levels_q.size() == 0) begin
        bad = 1'b1;
        if (n_mismatch < 10) $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pin_levels_q.pop_front();
        if (got.scl_pull_low !== want.scl_pull_low || got.sda_pull_low !== want.sda_pull_low ||
            got.busy_res !== want.busy_res) begin
          bad = 1'b1;
          if (n_mismatch < 10)
            $display("result %0d: scl %b/%b sda %b/%b busy %b/%b (expected/actual)",
                     results_seen, want.scl_pull_low, got.scl_pull_low,
                     want.sda_pull_low, got.sda_pull_low, want.busy_res, got.busy_res);
        end
      end
      if (bad) n_mismatch++;
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off to back the block up
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(16, 96);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (rx_cycle % 5 < 2);
      endcase
    end
  end

  // Watchdog: cycles with no handshake on either channel; also counts stalled input cycles
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (in_valid && in_stall) in_stall_cycles <= in_stall_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("i2c_master_write_sequencer: mismatch");
      $finish;
    end
  end

endmodule
